FILE: hw/rtl/pfs_pkg.sv
// Shared constants and types for the page framebuffer scan-out core.
`default_nettype none

package pfs_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int PAGE_ROWS         = 8;

    typedef logic [2:0] req_t;
    typedef logic [1:0] scan_mode_t;

    // request kinds
    localparam req_t REQ_PIXEL     = 3'd0;
    localparam req_t REQ_CLR_RECT  = 3'd1;
    localparam req_t REQ_CLR_ALL   = 3'd2;
    localparam req_t REQ_REF_PAGES = 3'd3;
    localparam req_t REQ_REF_COLS  = 3'd4;
    localparam req_t REQ_TICK      = 3'd5;

    // scan modes
    localparam scan_mode_t MODE_IDLE    = 2'd0;
    localparam scan_mode_t MODE_PAGES   = 2'd1;
    localparam scan_mode_t MODE_COLUMNS = 2'd2;

    // link command bytes
    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_COL_LO  = 8'h00;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

endpackage

`default_nettype wire

FILE: hw/rtl/page_framebuffer_scanout_core.sv
// Page-addressed monochrome frame buffer with byte-serial refresh scan-out.
`default_nettype none

// Requests enter on the s_ group: s_tuser carries the request kind, s_tdata the
// coordinates, sizes and the pixel value. Refresh bytes leave on the m_ group,
// one transfer per link tick that arrives while a refresh runs.
// The image lives in one synchronous RAM (one write, one read port, registered read
// data); pixel and region requests are read-modify-write against that RAM:
//   pixel set/clear        : read, then merged write-back
//   region clear           : setup, then read + masked write per byte (column x page)
//   clear all              : setup, then zero write of every byte, one byte per cycle
//   link tick in a refresh : RAM read, then load of the output register
//   refresh start, others  : done on acceptance, without RAM access
// Only one request is in flight; s_tready is high whenever the sequencer is idle.
// The result register parts the two sides: new requests are taken while a
// byte waits on m_, and a tick that finds the register still full waits in its
// load cycle until the receiver takes the previous byte.
// Reset clears control state and starts a clearing pass that zeroes all
// SCREEN_WIDTH*pages bytes of the RAM (1024 at default size); no request is taken
// during that pass. The first byte of a refresh appears on the tick that
// follows the refresh request.
module page_framebuffer_scanout_core
    import pfs_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] pos_x, [15:8] pos_y, [23:16] region_width, [31:24] region_height,
    // [32] pixel_on, [39:33] zero
    input  wire logic [39:0] s_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]       m_tdata,
    // [0] is_data
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_PIXEL  = 3'd2;
    localparam logic [2:0] ST_REG_RD = 3'd3;
    localparam logic [2:0] ST_REG_WR = 3'd4;
    localparam logic [2:0] ST_TICK   = 3'd5;

    // request fields
    req_t       req;
    logic [7:0] in_x, in_y, in_w, in_h;
    logic       in_on;

    assign req   = s_tuser;
    assign in_x  = s_tdata[7:0];
    assign in_y  = s_tdata[15:8];
    assign in_w  = s_tdata[23:16];
    assign in_h  = s_tdata[31:24];
    assign in_on = s_tdata[32];

    // image RAM
    logic [7:0]        store_mem [STORE_SIZE];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= store_mem[mem_raddr];
        end
    end

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PG_W-1:0] pg,
                                                  input logic [COL_W-1:0] col);
        addr_of = ADDR_W'(int'(pg) * SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

    // control state
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    scan_mode_t        scan_mode_reg, scan_mode_next;
    logic [PG_W-1:0]   scan_page_reg, scan_page_next;
    logic [COL_W-1:0]  scan_col_reg, scan_col_next;
    logic [1:0]        scan_phase_reg, scan_phase_next;
    logic              out_full_reg, out_full_next;

    // operand registers (payload)
    logic [ADDR_W-1:0] op_addr_reg, op_addr_next;
    logic [7:0]        op_mask_reg, op_mask_next;
    logic              op_set_reg, op_set_next;
    logic [COL_W-1:0]  rg_col_reg, rg_col_next;
    logic [COL_W-1:0]  rg_col_first_reg, rg_col_first_next;
    logic [COL_W-1:0]  rg_col_last_reg, rg_col_last_next;
    logic [PG_W-1:0]   rg_page_reg, rg_page_next;
    logic [PG_W-1:0]   rg_page_last_reg, rg_page_last_next;
    logic [ROW_W-1:0]  rg_y_lo_reg, rg_y_lo_next;
    logic [ROW_W-1:0]  rg_y_hi_reg, rg_y_hi_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    // clipped rectangle of a region request
    logic [8:0] x_end, y_end, x_sum, y_sum;
    logic       rect_empty;

    assign x_sum      = 9'(in_x) + 9'(in_w);
    assign y_sum      = 9'(in_y) + 9'(in_h);
    assign x_end      = (x_sum > 9'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH) : x_sum;
    assign y_end      = (y_sum > 9'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT) : y_sum;
    assign rect_empty = (9'(in_x) >= x_end) || (9'(in_y) >= y_end);

    // rows of the current region page that fall inside [y_lo, y_hi)
    logic [7:0] rg_mask;

    always_comb
    begin
        logic [ROW_W+3:0] row;
        for (int b = 0; b < PAGE_ROWS; b++)
        begin
            row = (ROW_W+4)'({rg_page_reg, 3'(b)});
            rg_mask[b] = (row >= (ROW_W+4)'(rg_y_lo_reg)) && (row < (ROW_W+4)'(rg_y_hi_reg));
        end
    end

    logic pix_on_screen, scan_busy, out_free;

    assign pix_on_screen = (in_x < 8'(SCREEN_WIDTH)) && (9'(in_y) < 9'(SCREEN_HEIGHT));
    assign scan_busy     = (scan_mode_reg != MODE_IDLE);
    assign out_free      = !out_full_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        scan_mode_next    = scan_mode_reg;
        scan_page_next    = scan_page_reg;
        scan_col_next     = scan_col_reg;
        scan_phase_next   = scan_phase_reg;
        out_full_next     = out_full_reg && !m_tready;
        op_addr_next      = op_addr_reg;
        op_mask_next      = op_mask_reg;
        op_set_next       = op_set_reg;
        rg_col_next       = rg_col_reg;
        rg_col_first_next = rg_col_first_reg;
        rg_col_last_next  = rg_col_last_reg;
        rg_page_next      = rg_page_reg;
        rg_page_last_next = rg_page_last_reg;
        rg_y_lo_next      = rg_y_lo_reg;
        rg_y_hi_next      = rg_y_hi_reg;
        out_byte_next     = out_byte_reg;
        out_data_next     = out_data_reg;
        out_last_next     = out_last_reg;
        mem_we            = 1'b0;
        mem_waddr         = op_addr_reg;
        mem_wdata         = 8'h00;
        mem_re            = 1'b0;
        mem_raddr         = addr_of(scan_page_reg, scan_col_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (req)
                        REQ_PIXEL:
                        begin
                            if (!scan_busy && pix_on_screen)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = addr_of(PG_W'(in_y >> 3), COL_W'(in_x));
                                op_addr_next = mem_raddr;
                                op_mask_next = 8'h01 << in_y[2:0];
                                op_set_next  = in_on;
                                state_next   = ST_PIXEL;
                            end
                        end
                        REQ_CLR_RECT:
                        begin
                            if (!scan_busy && !rect_empty)
                            begin
                                rg_col_next       = COL_W'(in_x);
                                rg_col_first_next = COL_W'(in_x);
                                rg_col_last_next  = COL_W'(x_end - 9'd1);
                                rg_page_next      = PG_W'(in_y >> 3);
                                rg_page_last_next = PG_W'((y_end - 9'd1) >> 3);
                                rg_y_lo_next      = ROW_W'(in_y);
                                rg_y_hi_next      = ROW_W'(y_end);
                                state_next        = ST_REG_RD;
                            end
                        end
                        REQ_CLR_ALL:
                        begin
                            if (!scan_busy)
                            begin
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end
                        end
                        REQ_REF_PAGES, REQ_REF_COLS:
                        begin
                            if (!scan_busy)
                            begin
                                scan_mode_next  = (req == REQ_REF_PAGES) ? MODE_PAGES
                                                                         : MODE_COLUMNS;
                                scan_page_next  = '0;
                                scan_col_next   = '0;
                                scan_phase_next = 2'd0;
                            end
                        end
                        REQ_TICK:
                        begin
                            // fetch the current byte up front; used only on data phases
                            if (scan_busy)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_TICK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 8'h00;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PIXEL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = op_addr_reg;
                mem_wdata  = op_set_reg ? (mem_rdata_reg | op_mask_reg)
                                        : (mem_rdata_reg & ~op_mask_reg);
                state_next = ST_IDLE;
            end

            ST_REG_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_of(rg_page_reg, rg_col_reg);
                state_next = ST_REG_WR;
            end

            ST_REG_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_of(rg_page_reg, rg_col_reg);
                mem_wdata  = mem_rdata_reg & ~rg_mask;
                state_next = ST_REG_RD;
                if (rg_col_reg == rg_col_last_reg)
                begin
                    rg_col_next = rg_col_first_reg;
                    if (rg_page_reg == rg_page_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rg_page_next = rg_page_reg + 1'b1;
                    end
                end
                else
                begin
                    rg_col_next = rg_col_reg + 1'b1;
                end
            end

            ST_TICK:
            begin
                if (out_free)
                begin
                    out_full_next = 1'b1;
                    out_data_next = 1'b0;
                    out_last_next = 1'b0;
                    state_next    = ST_IDLE;
                    if (scan_mode_reg == MODE_PAGES)
                    begin
                        unique case (scan_phase_reg)
                            2'd0:
                            begin
                                out_byte_next   = CMD_PAGE + 8'(scan_page_reg);
                                scan_phase_next = 2'd1;
                            end
                            2'd1:
                            begin
                                out_byte_next   = CMD_COL_LO;
                                scan_phase_next = 2'd2;
                            end
                            2'd2:
                            begin
                                out_byte_next   = CMD_COL_HI;
                                scan_phase_next = 2'd3;
                                scan_col_next   = '0;
                            end
                            default:
                            begin
                                out_byte_next = mem_rdata_reg;
                                out_data_next = 1'b1;
                                if (scan_col_reg == COL_W'(SCREEN_WIDTH - 1))
                                begin
                                    scan_col_next   = '0;
                                    scan_phase_next = 2'd0;
                                    if (scan_page_reg == PG_W'(PAGE_COUNT - 1))
                                    begin
                                        out_last_next  = 1'b1;
                                        scan_mode_next = MODE_IDLE;
                                        scan_page_next = '0;
                                    end
                                    else
                                    begin
                                        scan_page_next = scan_page_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    scan_col_next = scan_col_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (scan_phase_reg)
                            2'd0:
                            begin
                                out_byte_next   = CMD_COL_LO + (8'(scan_col_reg) & NIBBLE_MASK);
                                scan_phase_next = 2'd1;
                            end
                            2'd1:
                            begin
                                out_byte_next   = CMD_COL_HI
                                                + ((8'(scan_col_reg) >> 4) & NIBBLE_MASK);
                                scan_phase_next = 2'd2;
                                scan_page_next  = '0;
                            end
                            2'd2:
                            begin
                                out_byte_next   = CMD_PAGE + 8'(scan_page_reg);
                                scan_phase_next = 2'd3;
                            end
                            default:
                            begin
                                out_byte_next = mem_rdata_reg;
                                out_data_next = 1'b1;
                                if (scan_page_reg == PG_W'(PAGE_COUNT - 1))
                                begin
                                    scan_page_next  = '0;
                                    scan_phase_next = 2'd0;
                                    if (scan_col_reg == COL_W'(SCREEN_WIDTH - 1))
                                    begin
                                        out_last_next  = 1'b1;
                                        scan_mode_next = MODE_IDLE;
                                        scan_col_next  = '0;
                                    end
                                    else
                                    begin
                                        scan_col_next = scan_col_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    scan_page_next  = scan_page_reg + 1'b1;
                                    scan_phase_next = 2'd2;
                                end
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            scan_mode_reg  <= MODE_IDLE;
            scan_page_reg  <= '0;
            scan_col_reg   <= '0;
            scan_phase_reg <= 2'd0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_mode_reg  <= scan_mode_next;
            scan_page_reg  <= scan_page_next;
            scan_col_reg   <= scan_col_next;
            scan_phase_reg <= scan_phase_next;
            out_full_reg   <= out_full_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_addr_reg      <= op_addr_next;
        op_mask_reg      <= op_mask_next;
        op_set_reg       <= op_set_next;
        rg_col_reg       <= rg_col_next;
        rg_col_first_reg <= rg_col_first_next;
        rg_col_last_reg  <= rg_col_last_next;
        rg_page_reg      <= rg_page_next;
        rg_page_last_reg <= rg_page_last_next;
        rg_y_lo_reg      <= rg_y_lo_next;
        rg_y_hi_reg      <= rg_y_hi_next;
        out_byte_reg     <= out_byte_next;
        out_data_reg     <= out_data_next;
        out_last_reg     <= out_last_next;
    end

    assign m_tvalid   = out_full_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_data_reg;
    assign m_tlast    = out_last_reg;

endmodule

`default_nettype wire
